[src/pcgbr_pkg.sv]
// Shared types, constants and the output permutation of the PCG32 generator.
// Used by pcgbr_divider and pcg32_bounded_random_core; no dependencies.
package pcgbr_pkg;

    typedef logic [31:0] t_word;
    typedef logic [63:0] t_dword;

    localparam t_dword PCG_MULT   = 64'd6364136223846793005;
    localparam t_dword STATE_INIT = 64'h853c_49e6_748f_ea9b;
    localparam t_dword INC_INIT   = 64'hda3e_39cb_94b9_5bdb;
    localparam t_word  WORD_MASK  = 32'hFFFF_FFFF;

    localparam logic [1:0] CMD_RESEED  = 2'd0;
    localparam logic [1:0] CMD_RAW     = 2'd1;
    localparam logic [1:0] CMD_BOUNDED = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // request to the remainder unit
    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    // XSH-RR: xor-shift, then rotate right by the top five bits
    function automatic t_word xsh_rr(input t_dword prev);
        t_dword     x;
        t_word      mixed;
        logic [4:0] turn;
        logic [4:0] lturn;
        x     = (prev >> 18) ^ prev;
        mixed = x[58:27];
        turn  = prev[63:59];
        lturn = 5'd0 - turn;
        return (mixed >> turn) | (mixed << lturn);
    endfunction

endpackage

[src/pcg32_bounded_random_core.sv]
// PCG32 XSH-RR generator with reseed, raw draw, bounded draw by rejection and no-op.
// A generator step runs M0, M1, M2, M3 and MADD (three 32x32 partial products on one
// shared multiplier, then the 64-bit add). A reseed steps, adds the seed and steps
// again; a bounded draw steps until a word is accepted. One item at a time.
// Reset (synchronous, active low) loads the generator's initial state and increment.
module pcg32_bounded_random_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_command,
    input  logic [63:0]          i_seed_value,
    input  logic signed [31:0]   i_range_low,
    input  logic signed [31:0]   i_range_high,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_raw_word,
    output logic signed [31:0]   o_bounded_value
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_M0      = 4'd1;
    localparam logic [3:0] ST_M1      = 4'd2;
    localparam logic [3:0] ST_M2      = 4'd3;
    localparam logic [3:0] ST_M3      = 4'd4;
    localparam logic [3:0] ST_MADD    = 4'd5;
    localparam logic [3:0] ST_SEEDADD = 4'd6;
    localparam logic [3:0] ST_DIVLIM  = 4'd7;
    localparam logic [3:0] ST_DIVMOD  = 4'd8;
    localparam logic [3:0] ST_FIN     = 4'd9;

    logic [3:0]        r_st, n_st;
    pcgbr_pkg::t_dword r_state, n_state;
    pcgbr_pkg::t_dword r_inc, n_inc;
    pcgbr_pkg::t_dword r_seed, n_seed;
    logic [1:0]        r_cmd, n_cmd;
    logic              r_first, n_first;
    logic              r_full, n_full;
    pcgbr_pkg::t_word  r_lo, n_lo;
    pcgbr_pkg::t_word  r_span, n_span;
    pcgbr_pkg::t_word  r_limit, n_limit;
    pcgbr_pkg::t_word  r_word, n_word;
    pcgbr_pkg::t_dword r_prod;
    pcgbr_pkg::t_dword r_acc, n_acc;
    pcgbr_pkg::t_word  r_res_raw, n_res_raw;
    pcgbr_pkg::t_word  r_res_bnd, n_res_bnd;
    logic              r_out_valid, n_out_valid;
    pcgbr_pkg::t_word  r_out_raw, n_out_raw;
    pcgbr_pkg::t_word  r_out_bnd, n_out_bnd;

    pcgbr_pkg::t_word  w_mul_a, w_mul_b;
    pcgbr_pkg::t_dword w_prod;
    pcgbr_pkg::t_word  w_span;
    logic              w_in_xfer;
    pcgbr_pkg::t_div_req w_div_req;
    logic              w_div_done;
    pcgbr_pkg::t_word  w_div_rem;

    assign w_in_xfer = i_in_valid && o_in_ready;
    assign w_span    = pcgbr_pkg::t_word'(i_range_high) - pcgbr_pkg::t_word'(i_range_low)
                       + 32'd1;

    // shared 32x32 multiplier, operands picked by the step phase
    always_comb begin
        w_mul_a = r_state[31:0];
        w_mul_b = pcgbr_pkg::PCG_MULT[31:0];
        unique case (r_st)
            ST_M1:   w_mul_b = pcgbr_pkg::PCG_MULT[63:32];
            ST_M2:   w_mul_a = r_state[63:32];
            default: ;
        endcase
    end
    assign w_prod = 64'(w_mul_a) * 64'(w_mul_b);

    pcgbr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_rem   (w_div_rem)
    );

    always_comb begin
        n_st        = r_st;
        n_state     = r_state;
        n_inc       = r_inc;
        n_seed      = r_seed;
        n_cmd       = r_cmd;
        n_first     = r_first;
        n_full      = r_full;
        n_lo        = r_lo;
        n_span      = r_span;
        n_limit     = r_limit;
        n_word      = r_word;
        n_acc       = r_acc;
        n_res_raw   = r_res_raw;
        n_res_bnd   = r_res_bnd;
        n_out_valid = r_out_valid;
        n_out_raw   = r_out_raw;
        n_out_bnd   = r_out_bnd;
        w_div_req   = '{start: 1'b0, dividend: r_word, divisor: r_span};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_st)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_cmd     = i_command;
                    n_seed    = i_seed_value;
                    n_lo      = i_range_low;
                    n_span    = w_span;
                    n_first   = 1'b1;
                    n_full    = 1'b0;
                    n_res_raw = '0;
                    n_res_bnd = '0;
                    unique case (i_command)
                        pcgbr_pkg::CMD_RESEED: begin
                            n_state = '0;
                            n_inc   = {i_seed_value[62:0], 1'b1};
                            n_st    = ST_M0;
                        end
                        pcgbr_pkg::CMD_RAW: begin
                            n_st = ST_M0;
                        end
                        pcgbr_pkg::CMD_BOUNDED: begin
                            if (i_range_low >= i_range_high) begin
                                n_res_bnd = i_range_low;
                                n_st      = ST_FIN;
                            end else if (w_span == '0) begin
                                n_full = 1'b1;
                                n_st   = ST_M0;
                            end else begin
                                // limit = (2^32-1) - (2^32-1) % span
                                w_div_req = '{start: 1'b1, dividend: pcgbr_pkg::WORD_MASK,
                                              divisor: w_span};
                                n_st = ST_DIVLIM;
                            end
                        end
                        pcgbr_pkg::CMD_NONE: begin
                            n_st = ST_FIN;
                        end
                    endcase
                end
            end
            ST_M0: begin
                n_word = pcgbr_pkg::xsh_rr(r_state);
                n_st   = ST_M1;
            end
            ST_M1: begin
                n_acc = r_prod;
                n_st  = ST_M2;
            end
            ST_M2: begin
                n_acc[63:32] = r_acc[63:32] + r_prod[31:0];
                n_st         = ST_M3;
            end
            ST_M3: begin
                n_acc[63:32] = r_acc[63:32] + r_prod[31:0];
                n_st         = ST_MADD;
            end
            ST_MADD: begin
                n_state = r_acc + {r_inc[63:1], 1'b1};
                n_st    = ST_FIN;
                if (r_cmd == pcgbr_pkg::CMD_RESEED) begin
                    if (r_first) begin
                        n_first = 1'b0;
                        n_st    = ST_SEEDADD;
                    end
                end else if (r_cmd == pcgbr_pkg::CMD_RAW || r_full) begin
                    n_res_raw = r_word;
                    n_res_bnd = r_lo + r_word;
                    if (r_cmd == pcgbr_pkg::CMD_RAW) begin
                        n_res_bnd = '0;
                    end
                end else if (r_word >= r_limit) begin
                    n_st = ST_M0;   // rejected, draw again
                end else begin
                    w_div_req.start = 1'b1;
                    n_st            = ST_DIVMOD;
                end
            end
            ST_SEEDADD: begin
                n_state = r_state + r_seed;
                n_st    = ST_M0;
            end
            ST_DIVLIM: begin
                if (w_div_done) begin
                    n_limit = ~w_div_rem;
                    n_st    = ST_M0;
                end
            end
            ST_DIVMOD: begin
                if (w_div_done) begin
                    n_res_raw = r_word;
                    n_res_bnd = r_lo + w_div_rem;
                    n_st      = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_raw   = r_res_raw;
                    n_out_bnd   = r_res_bnd;
                    n_st        = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_state     <= pcgbr_pkg::STATE_INIT;
            r_inc       <= pcgbr_pkg::INC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_state     <= n_state;
            r_inc       <= n_inc;
            r_out_valid <= n_out_valid;
        end
        r_seed    <= n_seed;
        r_cmd     <= n_cmd;
        r_first   <= n_first;
        r_full    <= n_full;
        r_lo      <= n_lo;
        r_span    <= n_span;
        r_limit   <= n_limit;
        r_word    <= n_word;
        r_prod    <= w_prod;
        r_acc     <= n_acc;
        r_res_raw <= n_res_raw;
        r_res_bnd <= n_res_bnd;
        r_out_raw <= n_out_raw;
        r_out_bnd <= n_out_bnd;
    end

    assign o_in_ready      = (r_st == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_raw_word      = r_out_raw;
    assign o_bounded_value = r_out_bnd;

`ifndef ASSERT_OFF
    // the increment added by every step stays odd
    a_inc_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_inc[0])
        else $error("stream increment lost its low bit");

    // the remainder unit only finishes while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_st == ST_DIVLIM || r_st == ST_DIVMOD))
        else $error("remainder unit finished outside a wait state");

    // an accepted transfer always starts work or goes straight to the result stage
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_st != ST_IDLE))
        else $error("sequencer stayed idle after an input transfer");
`endif

endmodule

[src/pcgbr_divider.sv]
// Restoring radix-2 remainder unit, one quotient bit per cycle.
// Depends on pcgbr_pkg for t_word and t_div_req.
module pcgbr_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcgbr_pkg::t_div_req i_req,
    output logic              o_done,
    output pcgbr_pkg::t_word  o_rem
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [4:0]       r_cnt, n_cnt;
    pcgbr_pkg::t_word r_rem, n_rem;
    pcgbr_pkg::t_word r_dvd, n_dvd;
    pcgbr_pkg::t_word r_dsr, n_dsr;
    logic [32:0]      w_shift;
    logic [32:0]      w_diff;

    assign w_shift = {r_rem, r_dvd[31]};
    assign w_diff  = w_shift - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd31;
            n_rem  = '0;
            n_dvd  = i_req.dividend;
            n_dsr  = i_req.divisor;
        end else if (r_busy) begin
            // w_diff[32] set means the shifted remainder is below the divisor
            n_rem = w_diff[32] ? w_shift[31:0] : w_diff[31:0];
            n_dvd = {r_dvd[30:0], 1'b0};
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for pcg32_bounded_random_core: predicts every draw from
// its own PCG32 XSH-RR generator copy and checks results in order. Uses pcgbr_pkg.
module tb_top;

    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int MAX_REPORTS  = 40;
    localparam pcgbr_pkg::t_word INT_MIN = 32'h8000_0000;
    localparam pcgbr_pkg::t_word INT_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        pcgbr_pkg::t_word raw;
        pcgbr_pkg::t_word bnd;
    } t_draw_result;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         in_command;
    logic [63:0]        in_seed;
    logic signed [31:0] in_low;
    logic signed [31:0] in_high;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [31:0]        out_raw;
    logic signed [31:0] out_bounded;

    // generator copy used for prediction
    pcgbr_pkg::t_dword lcg_q  = pcgbr_pkg::STATE_INIT;
    pcgbr_pkg::t_dword incr_q = pcgbr_pkg::INC_INIT;

    t_draw_result draws_pending[$];
    int           mismatch_cnt = 0;
    int           idle_cycles  = 0;
    bit           no_idle      = 1'b0;
    bit           hold_request = 1'b0;

    always #2 clk = ~clk;

    pcg32_bounded_random_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_command       (in_command),
        .i_seed_value    (in_seed),
        .i_range_low     (in_low),
        .i_range_high    (in_high),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_raw_word      (out_raw),
        .o_bounded_value (out_bounded)
    );

    // one LCG step; returns the permuted word of the old state
    function automatic pcgbr_pkg::t_word lcg_advance();
        pcgbr_pkg::t_dword prev;
        pcgbr_pkg::t_word  folded;
        pcgbr_pkg::t_dword twin;
        prev   = lcg_q;
        lcg_q  = prev * pcgbr_pkg::PCG_MULT + (incr_q | 64'd1);
        folded = pcgbr_pkg::t_word'(((prev >> 18) ^ prev) >> 27);
        twin   = {folded, folded} >> prev[63:59];
        return twin[31:0];
    endfunction

    function automatic void predict_draw(input logic [1:0] cmd,
                                         input pcgbr_pkg::t_dword seed,
                                         input pcgbr_pkg::t_word lo,
                                         input pcgbr_pkg::t_word hi);
        t_draw_result     res;
        pcgbr_pkg::t_word span;
        pcgbr_pkg::t_word limit;
        pcgbr_pkg::t_word word;
        res = '0;
        case (cmd)
            pcgbr_pkg::CMD_RESEED: begin
                lcg_q  = '0;
                incr_q = {seed[62:0], 1'b1};
                void'(lcg_advance());
                lcg_q  = lcg_q + seed;
                void'(lcg_advance());
            end
            pcgbr_pkg::CMD_RAW: res.raw = lcg_advance();
            pcgbr_pkg::CMD_BOUNDED: begin
                if ($signed(lo) >= $signed(hi)) begin
                    res.bnd = lo;
                end else begin
                    span = hi - lo + 32'd1;
                    if (span == '0) begin
                        // full 2^32 range: any word is in range
                        res.raw = lcg_advance();
                        res.bnd = lo + res.raw;
                    end else begin
                        limit = (pcgbr_pkg::WORD_MASK / span) * span;
                        word  = lcg_advance();
                        while (word >= limit)
                            word = lcg_advance();
                        res.raw = word;
                        res.bnd = lo + (word % span);
                    end
                end
            end
            default: ;
        endcase
        draws_pending.push_back(res);
    endfunction

    function automatic pcgbr_pkg::t_dword rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 9)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    task automatic report_mismatch(input string field, input pcgbr_pkg::t_word exp_v,
                                   input pcgbr_pkg::t_word act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: %s expected %h actual %h", $time, field, exp_v, act_v);
    endtask

    task automatic send_item(input logic [1:0] cmd, input pcgbr_pkg::t_dword seed,
                             input pcgbr_pkg::t_word lo, input pcgbr_pkg::t_word hi);
        int gap;
        gap = (no_idle || $urandom_range(0, 9) < 6) ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   = 1'b1;
        in_command = cmd;
        in_seed    = seed;
        in_low     = lo;
        in_high    = hi;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (draws_pending.size() != 0) @(posedge clk);
    endtask

    task automatic pick_range(output pcgbr_pkg::t_word lo, output pcgbr_pkg::t_word hi);
        case ($urandom_range(0, 9))
            0, 1: begin
                lo = $urandom;
                hi = $urandom;
            end
            2, 3: begin
                lo = $urandom;
                hi = lo + $urandom_range(1, 20);
            end
            4: begin
                lo = $urandom;
                hi = lo + $urandom_range(21, 100000);
            end
            5: begin
                lo = -$urandom_range(0, 1000);
                hi = $urandom_range(0, 1000);
            end
            6: begin
                // spans close to 2^32
                lo = INT_MIN + $urandom_range(0, 3);
                hi = INT_MAX - $urandom_range(0, 3);
            end
            7: begin
                // spans just around 2^31, rejection heavy for those above it
                lo = -$urandom_range(0, 8);
                hi = lo + 32'h7FFF_FFF0 + $urandom_range(0, 31);
            end
            8: begin
                lo = $urandom;
                hi = lo;
            end
            default: begin
                lo = INT_MIN;
                hi = INT_MAX;
            end
        endcase
    endtask

    task automatic send_random();
        int               pick;
        pcgbr_pkg::t_word lo;
        pcgbr_pkg::t_word hi;
        pick = $urandom_range(0, 19);
        pick_range(lo, hi);
        if (pick < 2)
            send_item(pcgbr_pkg::CMD_RESEED, rand64(), $urandom, $urandom);
        else if (pick < 9)
            send_item(pcgbr_pkg::CMD_RAW, rand64(), $urandom, $urandom);
        else if (pick < 19)
            send_item(pcgbr_pkg::CMD_BOUNDED, rand64(), lo, hi);
        else
            send_item(pcgbr_pkg::CMD_NONE, rand64(), $urandom, $urandom);
    endtask

    task automatic test_directed();
        no_idle = 1'b1;
        send_item(pcgbr_pkg::CMD_RAW, rand64(), $urandom, $urandom);
        send_item(pcgbr_pkg::CMD_RAW, rand64(), $urandom, $urandom);
        send_item(pcgbr_pkg::CMD_RESEED, 64'd0, $urandom, $urandom);
        send_item(pcgbr_pkg::CMD_RAW, rand64(), $urandom, $urandom);
        send_item(pcgbr_pkg::CMD_RESEED, '1, $urandom, $urandom);
        send_item(pcgbr_pkg::CMD_RAW, rand64(), $urandom, $urandom);
        // only the top seed bit set: it drops out of the increment
        send_item(pcgbr_pkg::CMD_RESEED, 64'h8000_0000_0000_0000, $urandom, $urandom);
        send_item(pcgbr_pkg::CMD_RAW, rand64(), $urandom, $urandom);
        send_item(pcgbr_pkg::CMD_RESEED, 64'd42, $urandom, $urandom);
        send_item(pcgbr_pkg::CMD_BOUNDED, rand64(), 32'd0, 32'd1);
        send_item(pcgbr_pkg::CMD_BOUNDED, rand64(), 32'd5, 32'd5);
        send_item(pcgbr_pkg::CMD_BOUNDED, rand64(), 32'd10, -32'sd10);
        send_item(pcgbr_pkg::CMD_BOUNDED, rand64(), INT_MAX, INT_MIN);
        send_item(pcgbr_pkg::CMD_BOUNDED, rand64(), INT_MIN, INT_MAX);
        send_item(pcgbr_pkg::CMD_BOUNDED, rand64(), INT_MIN, INT_MAX - 32'd1);
        send_item(pcgbr_pkg::CMD_BOUNDED, rand64(), 32'd0, INT_MAX);
        send_item(pcgbr_pkg::CMD_BOUNDED, rand64(), '1, INT_MAX);
        send_item(pcgbr_pkg::CMD_BOUNDED, rand64(), INT_MIN, INT_MIN + 32'd2);
        send_item(pcgbr_pkg::CMD_BOUNDED, rand64(), -32'sd100, 32'sd100);
        send_item(pcgbr_pkg::CMD_NONE, rand64(), $urandom, $urandom);
        send_item(pcgbr_pkg::CMD_NONE, '1, '1, '1);
        release_input();
        wait_drain();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int blk = 0; blk < 11; blk++) begin
            no_idle = (blk % 4 == 3);
            repeat (100) send_random();
        end
        release_input();
        wait_drain();
        no_idle = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so the core stalls its input
    task automatic test_output_backpressure();
        no_idle      = 1'b1;
        hold_request = 1'b1;
        repeat (10) send_random();
        release_input();
        wait_drain();
        hold_request = 1'b0;
        no_idle      = 1'b0;
    endtask

    // one long hold per request, counted here
    always begin : rx_drive
        int n;
        bit hold_done;
        @(negedge clk);
        if (hold_request && !hold_done) begin
            out_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_done = 1'b1;
        end else if (no_idle || $urandom_range(0, 9) < 7) begin
            out_ready = 1'b1;
        end else begin
            n = idle_len();
            out_ready = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    end

    // predict on every input transfer
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            predict_draw(in_command, in_seed, in_low, in_high);
    end

    always @(posedge clk) begin : result_check
        t_draw_result exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (draws_pending.size() == 0) begin
                report_mismatch("unexpected result raw_word", '0, out_raw);
            end else begin
                exp_r = draws_pending.pop_front();
                if (out_raw !== exp_r.raw)
                    report_mismatch("raw_word", exp_r.raw, out_raw);
                if (out_bounded !== exp_r.bnd)
                    report_mismatch("bounded_value", exp_r.bnd, out_bounded);
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_command = pcgbr_pkg::CMD_NONE;
        in_seed    = '0;
        in_low     = '0;
        in_high    = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_traffic();
        test_output_backpressure();

        repeat (100) @(posedge clk);
        if (mismatch_cnt == 0 && draws_pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
src/pcgbr_pkg.sv
src/pcgbr_divider.sv
src/pcg32_bounded_random_core.sv
bench/tb_top.sv
